### sv/amg_pkg.sv
package amg_pkg;

  // Address width of the byte memory; higher address bits alias.
  localparam int MEM_ADDR_BITS = 16;

  // Action codes.
  localparam logic [4:0] ACT_WRITE         = 5'd0;
  localparam logic [4:0] ACT_ABS_X_IND     = 5'd1;
  localparam logic [4:0] ACT_ABS_IND       = 5'd2;
  localparam logic [4:0] ACT_ABS_IND_LONG  = 5'd3;
  localparam logic [4:0] ACT_ABS           = 5'd4;
  localparam logic [4:0] ACT_ABS_X         = 5'd5;
  localparam logic [4:0] ACT_ABS_Y         = 5'd6;
  localparam logic [4:0] ACT_LONG_X        = 5'd7;
  localparam logic [4:0] ACT_DP            = 5'd8;
  localparam logic [4:0] ACT_DP_IND        = 5'd9;
  localparam logic [4:0] ACT_DP_IND_LONG   = 5'd10;
  localparam logic [4:0] ACT_DP_X          = 5'd11;
  localparam logic [4:0] ACT_DP_X_IND      = 5'd12;
  localparam logic [4:0] ACT_DP_Y          = 5'd13;
  localparam logic [4:0] ACT_DP_IND_Y      = 5'd14;
  localparam logic [4:0] ACT_DP_IND_LONG_Y = 5'd15;
  localparam logic [4:0] ACT_REL8          = 5'd16;
  localparam logic [4:0] ACT_REL16         = 5'd17;
  localparam logic [4:0] ACT_LONG          = 5'd18;
  localparam logic [4:0] ACT_IMM           = 5'd19;
  localparam logic [4:0] ACT_SR            = 5'd20;
  localparam logic [4:0] ACT_SR_IND_Y      = 5'd21;

  // How the shared adder wraps its result.
  typedef enum logic [1:0] {
    WRAP_FULL,
    WRAP_BANK,
    WRAP_PAGE
  } wrap_t;

  // Number of operand bytes that follow the opcode for each mode.
  function automatic logic [1:0] op_bytes(input logic [4:0] mode);
    logic [1:0] n;
    case (mode) inside
      ACT_LONG_X, ACT_LONG:                    n = 2'd3;
      [ACT_ABS_X_IND : ACT_ABS_Y], ACT_REL16:  n = 2'd2;
      ACT_IMM:                                 n = 2'd0;
      default:                                 n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

### sv/address_mode_generator.sv
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------------
// request   | action, prog_counter, program_bank, ...   | taken when start && !busy
//           | ..., emulation, mem_address, mem_data     |
// result    | effective_address                         | valid for one cycle with done
//
// A memory write (action 0) completes in the cycle it is taken and leaves busy low.
// A mode request is busy for the address step S_OPADR, then S_RD and S_CAP for each
// byte read from the single-port memory, S_CALC and for some modes S_CALC2 (none for
// immediate), and S_FINAL when a pointer is read. The longest is [a], five bytes read.
// done rises as busy falls; a new request may be taken in that cycle.
// rst clears the sequencer and done, not the memory. The receiver cannot stall.
module address_mode_generator
  import amg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  action,
  input  logic [15:0] prog_counter,
  input  logic [7:0]  program_bank,
  input  logic [7:0]  data_bank,
  input  logic [15:0] direct_base,
  input  logic [15:0] index_x,
  input  logic [15:0] index_y,
  input  logic [15:0] stack_ptr,
  input  logic        emulation,
  input  logic [23:0] mem_address,
  input  logic [7:0]  mem_data,
  output logic        done,
  output logic [23:0] effective_address
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPADR,
    S_RD,
    S_CAP,
    S_CALC,
    S_CALC2,
    S_FINAL
  } state_t;

  state_t      state;
  logic [4:0]  mode;
  logic [7:0]  pbr;
  logic [7:0]  dbr;
  logic [15:0] dpr;
  logic [15:0] xr;
  logic [15:0] yr;
  logic [15:0] spr;
  logic        emu_page;
  logic [23:0] addr;
  logic [23:0] buf_q;
  logic [1:0]  idx;
  logic [1:0]  nbytes;
  wrap_t       fwrap;
  logic        ptr_phase;
  logic [7:0]  rdata;

  logic [7:0]  mem [0:(2**MEM_ADDR_BITS)-1];

  logic        accept;
  logic        mem_we;

  // Shared adder and its operand selection.
  logic [23:0] add_a;
  logic [23:0] add_b;
  wrap_t       add_w;
  logic [23:0] add_sum;
  logic [23:0] add_y;

  // Mode decode for the step after the operand is read.
  logic        calc_done;
  logic        need_ptr;
  logic [1:0]  ptr_bytes;
  wrap_t       ptr_wrap;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign mem_we = accept && (action == ACT_WRITE);

  // Single-port byte memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_address[MEM_ADDR_BITS-1:0]] <= mem_data;
    end else if (state == S_RD) begin
      rdata <= mem[addr[MEM_ADDR_BITS-1:0]];
    end
  end

  // Operand selection for the adder in each step.
  always_comb begin
    add_a = addr;
    add_b = 24'd0;
    add_w = WRAP_FULL;
    case (state)
      S_OPADR, S_RD: begin
        add_a = addr;
        add_b = 24'd1;
        add_w = (state == S_RD) ? fwrap : WRAP_BANK;
      end
      S_CALC: begin
        case (mode) inside
          ACT_ABS_X_IND: begin
            add_a = {pbr, buf_q[15:0]};
            add_b = {8'd0, xr};
            add_w = WRAP_BANK;
          end
          ACT_ABS_IND, ACT_ABS_IND_LONG: begin
            add_a = {8'd0, buf_q[15:0]};
            add_w = WRAP_BANK;
          end
          ACT_ABS: begin
            add_a = {dbr, buf_q[15:0]};
          end
          ACT_ABS_X, ACT_ABS_Y: begin
            add_a = {dbr, buf_q[15:0]};
            add_b = {8'd0, (mode == ACT_ABS_X) ? xr : yr};
          end
          ACT_LONG_X: begin
            add_a = buf_q;
            add_b = {8'd0, xr};
          end
          ACT_SR, ACT_SR_IND_Y: begin
            add_a = {8'd0, spr};
            add_b = {16'd0, buf_q[7:0]};
            add_w = WRAP_BANK;
          end
          ACT_REL8: begin
            add_a = addr;
            add_b = {{16{buf_q[7]}}, buf_q[7:0]};
            add_w = WRAP_BANK;
          end
          ACT_REL16: begin
            add_a = addr;
            add_b = {8'd0, buf_q[15:0]};
            add_w = WRAP_BANK;
          end
          ACT_LONG: begin
            add_a = buf_q;
          end
          default: begin
            // Direct-page modes start from D plus the operand byte.
            add_a = {8'd0, dpr};
            add_b = {16'd0, buf_q[7:0]};
            add_w = WRAP_BANK;
          end
        endcase
      end
      S_CALC2: begin
        add_a = addr;
        add_b = {8'd0, (mode == ACT_DP_Y) ? yr : xr};
        add_w = emu_page ? WRAP_PAGE : WRAP_BANK;
      end
      S_FINAL: begin
        if (mode inside {ACT_DP_IND, ACT_DP_X_IND, ACT_DP_IND_Y, ACT_SR_IND_Y}) begin
          add_a = {dbr, buf_q[15:0]};
        end else begin
          add_a = buf_q;
        end
        if (mode inside {ACT_DP_IND_Y, ACT_DP_IND_LONG_Y, ACT_SR_IND_Y}) begin
          add_b = {8'd0, yr};
        end
      end
      default: begin
        add_a = addr;
      end
    endcase
  end

  // The adder itself, with bank or page wrap taken from the first operand.
  assign add_sum = add_a + add_b;
  always_comb begin
    case (add_w)
      WRAP_BANK: add_y = {add_a[23:16], add_sum[15:0]};
      WRAP_PAGE: add_y = {add_a[23:8], add_sum[7:0]};
      default:   add_y = add_sum;
    endcase
  end

  // What happens after the operand step.
  always_comb begin
    calc_done = mode inside {ACT_ABS, ACT_ABS_X, ACT_ABS_Y, ACT_LONG_X, ACT_DP,
                             ACT_REL8, ACT_REL16, ACT_LONG, ACT_SR};
    need_ptr  = mode inside {ACT_ABS_X_IND, ACT_ABS_IND, ACT_ABS_IND_LONG, ACT_DP_IND,
                             ACT_DP_IND_LONG, ACT_DP_X_IND, ACT_DP_IND_Y,
                             ACT_DP_IND_LONG_Y, ACT_SR_IND_Y};
    ptr_bytes = (mode inside {ACT_ABS_IND_LONG, ACT_DP_IND_LONG, ACT_DP_IND_LONG_Y})
                ? 2'd3 : 2'd2;
    ptr_wrap  = (emu_page && (mode inside {ACT_DP_IND, ACT_DP_X_IND, ACT_DP_IND_Y}))
                ? WRAP_PAGE : WRAP_BANK;
  end

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (action != ACT_WRITE) && (action <= ACT_SR_IND_Y)) begin
            mode     <= action;
            pbr      <= program_bank;
            dbr      <= data_bank;
            dpr      <= direct_base;
            xr       <= index_x;
            yr       <= index_y;
            spr      <= stack_ptr;
            emu_page <= emulation && (direct_base[7:0] == 8'd0);
            addr     <= {program_bank, prog_counter};
            state    <= S_OPADR;
          end
        end
        S_OPADR: begin
          addr <= add_y;
          if (mode == ACT_IMM) begin
            effective_address <= add_y;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else begin
            idx       <= 2'd0;
            nbytes    <= op_bytes(mode);
            fwrap     <= WRAP_BANK;
            buf_q     <= 24'd0;
            ptr_phase <= 1'b0;
            state     <= S_RD;
          end
        end
        S_RD: begin
          addr  <= add_y;
          state <= S_CAP;
        end
        S_CAP: begin
          buf_q[idx*8 +: 8] <= rdata;
          if (idx == nbytes - 2'd1) begin
            state <= ptr_phase ? S_FINAL : S_CALC;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_RD;
          end
        end
        S_CALC: begin
          if (calc_done) begin
            effective_address <= add_y;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else if (need_ptr && (mode != ACT_DP_X_IND)) begin
            addr      <= add_y;
            idx       <= 2'd0;
            nbytes    <= ptr_bytes;
            fwrap     <= ptr_wrap;
            buf_q     <= 24'd0;
            ptr_phase <= 1'b1;
            state     <= S_RD;
          end else begin
            addr  <= add_y;
            state <= S_CALC2;
          end
        end
        S_CALC2: begin
          if (mode == ACT_DP_X_IND) begin
            addr      <= add_y;
            idx       <= 2'd0;
            nbytes    <= ptr_bytes;
            fwrap     <= ptr_wrap;
            buf_q     <= 24'd0;
            ptr_phase <= 1'b1;
            state     <= S_RD;
          end else begin
            effective_address <= add_y;
            done              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_FINAL: begin
          effective_address <= add_y;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // A result only ever follows a busy cycle.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a request in progress");

  // Results never come in consecutive cycles.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results in consecutive cycles");

  // A memory write produces no result and does not occupy the block.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_WRITE)) |=> (!busy && !done))
    else $error("memory write disturbed the sequencer");

  // A mode request always starts the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action != ACT_WRITE) && (action <= ACT_SR_IND_Y)) |=> busy)
    else $error("mode request not started");

  // The byte index stays within the fetch length.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_RD) || (state == S_CAP)) |-> ((nbytes != 2'd0) && (idx < nbytes)))
    else $error("fetch index out of range");
`endif

endmodule
